// ===== src/phb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the pixel histogram binner.
// No dependencies; every other file in src refers to this package by scoped names.
package phb_pkg;

  localparam int MAX_BINS_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;

  localparam int SAMPLE_W = 32;
  localparam int SEL_W    = 10;
  localparam int COUNT_W  = 32;
  localparam int BCNT_W   = 11;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    ACT_ACCUM = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    REG_BIN_COUNT   = 3'd0,
    REG_RANGE_LOW   = 3'd1,
    REG_BIN_SCALE   = 3'd2,
    REG_NODATA_EN   = 3'd3,
    REG_NODATA_VAL  = 3'd4,
    REG_INCLUDE_OOR = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [BCNT_W-1:0]          bin_count;
    logic signed [SAMPLE_W-1:0] range_low;
    logic [31:0]                bin_scale;
    logic                       nodata_enable;
    logic signed [SAMPLE_W-1:0] nodata_value;
    logic                       include_oor;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic init_busy;
  } back_status_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

// ===== src/phb_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input transfers, masks no-data samples and computes the bin.
// Uses phb_pkg; pushes classified items into phb_queue.
module phb_front #(
  parameter int MAX_BINS    = phb_pkg::MAX_BINS_DEF,
  parameter int SAMPLE_BITS = phb_pkg::SAMPLE_BITS_DEF,
  localparam int IDX_W      = $clog2(MAX_BINS),
  localparam int ITEM_W     = 2 + IDX_W + phb_pkg::SEL_W + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  phb_pkg::cfg_t                 cfg,
  input  logic                          hold,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [phb_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [phb_pkg::SEL_W-1:0]     in_bin_select,
  input  logic                          q_full,
  output logic                          push,
  output logic [ITEM_W-1:0]             push_data
);

  logic                              f_en;
  logic signed [phb_pkg::SAMPLE_W-1:0] s_ext;
  logic signed [phb_pkg::SAMPLE_W:0]   diff;
  logic                              in_hit;

  logic                              f1_valid_r;
  logic [1:0]                        f1_act_r;
  logic signed [phb_pkg::SAMPLE_W:0] f1_diff_r;
  logic                              f1_skip_r;
  logic [phb_pkg::SEL_W-1:0]         f1_sel_r;
  logic                              f1_hit_r;

  logic                              f2_valid_r;
  logic [1:0]                        f2_act_r;
  logic [63:0]                       f2_prod_r;
  logic                              f2_neg_r;
  logic                              f2_zscale_r;
  logic                              f2_skip_r;
  logic [phb_pkg::SEL_W-1:0]         f2_sel_r;
  logic                              f2_hit_r;

  logic [63:0]        prod;
  logic [47:0]        bin_wide;
  logic [31:0]        bc32;
  logic [31:0]        n32;
  logic [IDX_W-1:0]   last_bin;
  logic               above;
  logic               below;
  logic               keep_acc;
  logic               push_want;
  logic [IDX_W-1:0]   idx;

  assign f_en     = !f2_valid_r || !q_full;
  assign in_stall = !f_en || hold;

  assign s_ext  = phb_pkg::SAMPLE_W'(signed'(in_sample[SAMPLE_BITS-1:0]));
  assign diff   = (phb_pkg::SAMPLE_W+1)'(s_ext) - (phb_pkg::SAMPLE_W+1)'(cfg.range_low);
  assign in_hit = 32'(in_bin_select) < 32'(MAX_BINS);
  assign prod   = 64'(f1_diff_r[phb_pkg::SAMPLE_W-1:0]) * 64'(cfg.bin_scale);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (f_en) begin
      f1_valid_r  <= in_valid && !hold;
      f1_act_r    <= in_action;
      f1_diff_r   <= diff;
      f1_skip_r   <= cfg.nodata_enable && (s_ext == cfg.nodata_value);
      f1_sel_r    <= in_bin_select;
      f1_hit_r    <= in_hit;
      f2_valid_r  <= f1_valid_r;
      f2_act_r    <= f1_act_r;
      f2_prod_r   <= prod;
      f2_neg_r    <= f1_diff_r[phb_pkg::SAMPLE_W];
      f2_zscale_r <= (cfg.bin_scale == '0);
      f2_skip_r   <= f1_skip_r;
      f2_sel_r    <= f1_sel_r;
      f2_hit_r    <= f1_hit_r;
    end
  end

  // A zero bin count acts as one bin; counts above the store size are capped.
  always_comb begin
    bc32 = 32'(cfg.bin_count);
    if (bc32 == 32'd0) begin
      n32 = 32'd1;
    end else if (bc32 > 32'(MAX_BINS)) begin
      n32 = 32'(MAX_BINS);
    end else begin
      n32 = bc32;
    end
    last_bin = IDX_W'(n32 - 32'd1);
  end

  // The product is Q48.16, so dropping the low 16 bits gives the floor.
  assign bin_wide = f2_prod_r[63:16];
  assign above    = !f2_zscale_r && !f2_neg_r && (bin_wide > 48'(last_bin));
  assign below    = !f2_zscale_r && f2_neg_r;
  assign keep_acc = !f2_skip_r && (!(above || below) || cfg.include_oor);

  always_comb begin
    push_want = 1'b0;
    idx       = IDX_W'(f2_sel_r);
    case (f2_act_r)
      phb_pkg::ACT_ACCUM: begin
        push_want = keep_acc;
        if (f2_zscale_r || below) begin
          idx = '0;
        end else if (above) begin
          idx = last_bin;
        end else begin
          idx = bin_wide[IDX_W-1:0];
        end
      end
      phb_pkg::ACT_READ:  push_want = 1'b1;
      phb_pkg::ACT_CLEAR: push_want = 1'b1;
      default:            push_want = 1'b0;
    endcase
  end

  assign push      = f2_valid_r && push_want && !q_full;
  assign push_data = {f2_act_r, idx, f2_sel_r, f2_hit_r};

endmodule

// ===== src/phb_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO that decouples the binning front end from the count store.
// Uses phb_pkg only for its default depth.
module phb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = phb_pkg::QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             q_full,
  output logic             q_valid,
  output logic [WIDTH-1:0] q_data
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue pop while empty");

endmodule

// ===== src/phb_back.sv =====
`timescale 1ns / 1ps
// Back end: bin count store with read-modify-write, forwarding, clearing pass
// and the result register. Uses phb_pkg; fed from phb_queue.
module phb_back #(
  parameter int MAX_BINS = phb_pkg::MAX_BINS_DEF,
  localparam int IDX_W   = $clog2(MAX_BINS),
  localparam int ITEM_W  = 2 + IDX_W + phb_pkg::SEL_W + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  logic [ITEM_W-1:0]            q_data,
  output logic                         pop,
  output phb_pkg::back_status_t        status,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [phb_pkg::SEL_W-1:0]    out_bin_number,
  output logic [phb_pkg::COUNT_W-1:0]  out_bin_total,
  output logic [phb_pkg::COUNT_W-1:0]  out_nonnull_total
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BINS - 1);

  logic [phb_pkg::COUNT_W-1:0] bin_store [MAX_BINS];

  phb_pkg::act_t              q_act;
  logic [IDX_W-1:0]           q_idx;
  logic [phb_pkg::SEL_W-1:0]  q_sel;
  logic                       q_hit;

  logic                        back_en;
  logic                        b1_acc;
  logic                        b1_rd;
  logic [phb_pkg::COUNT_W-1:0] cur;
  logic [phb_pkg::COUNT_W-1:0] nv;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_wa;
  logic [phb_pkg::COUNT_W-1:0] mem_wd;

  logic                        b1_valid_r;
  phb_pkg::act_t               b1_act_r;
  logic [IDX_W-1:0]            b1_idx_r;
  logic [phb_pkg::SEL_W-1:0]   b1_sel_r;
  logic                        b1_hit_r;
  logic [phb_pkg::COUNT_W-1:0] rd_data_r;
  logic                        lw_valid_r;
  logic [IDX_W-1:0]            lw_addr_r;
  logic [phb_pkg::COUNT_W-1:0] lw_data_r;
  logic [phb_pkg::COUNT_W-1:0] total_r;
  logic                        clearing_r;
  logic                        init_r;
  logic [IDX_W-1:0]            clr_cnt_r;
  logic                        out_valid_r;
  logic [phb_pkg::SEL_W-1:0]   out_num_r;
  logic [phb_pkg::COUNT_W-1:0] out_bin_r;
  logic [phb_pkg::COUNT_W-1:0] out_tot_r;

  assign q_act = phb_pkg::act_t'(q_data[ITEM_W-1 -: 2]);
  assign q_idx = q_data[ITEM_W-3 -: IDX_W];
  assign q_sel = q_data[phb_pkg::SEL_W:1];
  assign q_hit = q_data[0];

  assign back_en = !out_valid_r || !out_stall;
  assign pop     = q_valid && back_en && !clearing_r;

  assign b1_acc = b1_valid_r && (b1_act_r == phb_pkg::ACT_ACCUM);
  assign b1_rd  = b1_valid_r && (b1_act_r == phb_pkg::ACT_READ);

  // The read register misses a write to the same bin made at the same edge,
  // so that write is forwarded from the last-write register.
  assign cur = (lw_valid_r && (lw_addr_r == b1_idx_r)) ? lw_data_r : rd_data_r;
  assign nv  = phb_pkg::sat_inc(cur);

  assign mem_we = clearing_r || (b1_acc && back_en);
  assign mem_wa = clearing_r ? clr_cnt_r : b1_idx_r;
  assign mem_wd = clearing_r ? '0 : nv;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_store[mem_wa] <= mem_wd;
    end
    if (pop) begin
      rd_data_r <= bin_store[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
      total_r     <= '0;
      clearing_r  <= 1'b1;
      init_r      <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (back_en) begin
        if (b1_acc) begin
          total_r <= phb_pkg::sat_inc(total_r);
        end
        lw_addr_r  <= b1_idx_r;
        lw_data_r  <= nv;
        if (b1_rd) begin
          out_valid_r <= 1'b1;
          out_num_r   <= b1_sel_r;
          out_bin_r   <= b1_hit_r ? cur : '0;
          out_tot_r   <= total_r;
        end else if (!out_stall) begin
          out_valid_r <= 1'b0;
        end
        b1_valid_r <= pop && (q_act != phb_pkg::ACT_CLEAR);
        b1_act_r   <= q_act;
        b1_idx_r   <= q_idx;
        b1_sel_r   <= q_sel;
        b1_hit_r   <= q_hit;
        if (pop && (q_act == phb_pkg::ACT_CLEAR)) begin
          clearing_r <= 1'b1;
          clr_cnt_r  <= '0;
        end
      end
      // The clearing pass wipes the store, so nothing may be forwarded past it.
      if (clearing_r) begin
        lw_valid_r <= 1'b0;
      end else if (back_en) begin
        lw_valid_r <= b1_acc;
      end
      if (clearing_r) begin
        clr_cnt_r  <= clr_cnt_r + 1'b1;
        total_r    <= '0;
        if (clr_cnt_r == LAST_IDX) begin
          clearing_r <= 1'b0;
          init_r     <= 1'b0;
        end
      end
    end
  end

  assign status.clearing  = clearing_r;
  assign status.init_busy = init_r;

  assign out_valid         = out_valid_r;
  assign out_bin_number    = out_num_r;
  assign out_bin_total     = out_bin_r;
  assign out_nonnull_total = out_tot_r;

  a_clear_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !b1_valid_r)
    else $error("bin update in flight during clearing pass");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> ($past(clr_cnt_r) == LAST_IDX))
    else $error("clearing pass ended before the last bin");

  a_read_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (b1_rd && back_en) |=> (out_valid_r && (out_num_r == $past(b1_sel_r))))
    else $error("bin read did not reach the result register");

endmodule

// ===== src/pixel_histogram_binner_top.sv =====
`timescale 1ns / 1ps
// Top level of the pixel histogram binner: APB register file plus the front end,
// queue and back end. Depends on phb_pkg, phb_front, phb_queue and phb_back.
//
// Usage: items arrive on the in_ channel (valid/stall). Action accumulate bins a
// sample, read returns one bin count with the non-null total on the out_ channel,
// clear zeroes the store. The user must write registers through the APB port
// only while idle; the block does not enforce this. Throughput: one item per
// cycle while in_stall is low. Each accumulate does one read-modify-write of the
// count memory; a repeat of the same bin on the next cycle is forwarded. A read
// item passes two front stages, the queue, the memory read and the result
// register before it shows on out_valid. Reset runs a clearing pass over every
// bin of the count memory; in_stall stays high until it ends. A clear action runs
// the same pass, during which transfers are taken only until the queue fills.
// When the receiver stalls, the result register holds its transfer and the back
// end pauses; the queue absorbs a few items before in_stall rises.
module pixel_histogram_binner_top #(
  parameter int MAX_BINS    = phb_pkg::MAX_BINS_DEF,
  parameter int SAMPLE_BITS = phb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [phb_pkg::ADDR_W-1:0]    paddr,
  input  logic [phb_pkg::DATA_W-1:0]    pwdata,
  output logic [phb_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [phb_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [phb_pkg::SEL_W-1:0]     in_bin_select,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [phb_pkg::SEL_W-1:0]     out_bin_number,
  output logic [phb_pkg::COUNT_W-1:0]   out_bin_total,
  output logic [phb_pkg::COUNT_W-1:0]   out_nonnull_total
);

  localparam int IDX_W  = $clog2(MAX_BINS);
  localparam int ITEM_W = 2 + IDX_W + phb_pkg::SEL_W + 1;

  logic [phb_pkg::BCNT_W-1:0]          bin_count_r;
  logic signed [phb_pkg::SAMPLE_W-1:0] range_low_r;
  logic [31:0]                         bin_scale_r;
  logic                                nodata_en_r;
  logic signed [phb_pkg::SAMPLE_W-1:0] nodata_val_r;
  logic                                include_oor_r;

  phb_pkg::cfg_t         cfg;
  phb_pkg::back_status_t status;
  logic [2:0]            reg_idx;
  logic                  wr_en;

  logic              push;
  logic [ITEM_W-1:0] push_data;
  logic              pop;
  logic              q_full;
  logic              q_valid;
  logic [ITEM_W-1:0] q_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[phb_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r   <= phb_pkg::BCNT_W'(256);
      range_low_r   <= '0;
      bin_scale_r   <= 32'h0001_0000;
      nodata_en_r   <= 1'b0;
      nodata_val_r  <= '0;
      include_oor_r <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        phb_pkg::REG_BIN_COUNT:   bin_count_r   <= pwdata[phb_pkg::BCNT_W-1:0];
        phb_pkg::REG_RANGE_LOW:   range_low_r   <= signed'(pwdata);
        phb_pkg::REG_BIN_SCALE:   bin_scale_r   <= pwdata;
        phb_pkg::REG_NODATA_EN:   nodata_en_r   <= pwdata[0];
        phb_pkg::REG_NODATA_VAL:  nodata_val_r  <= signed'(pwdata);
        phb_pkg::REG_INCLUDE_OOR: include_oor_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      phb_pkg::REG_BIN_COUNT:   prdata = phb_pkg::DATA_W'(bin_count_r);
      phb_pkg::REG_RANGE_LOW:   prdata = unsigned'(range_low_r);
      phb_pkg::REG_BIN_SCALE:   prdata = bin_scale_r;
      phb_pkg::REG_NODATA_EN:   prdata = phb_pkg::DATA_W'(nodata_en_r);
      phb_pkg::REG_NODATA_VAL:  prdata = unsigned'(nodata_val_r);
      phb_pkg::REG_INCLUDE_OOR: prdata = phb_pkg::DATA_W'(include_oor_r);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.bin_count     = bin_count_r;
  assign cfg.range_low     = range_low_r;
  assign cfg.bin_scale     = bin_scale_r;
  assign cfg.nodata_enable = nodata_en_r;
  assign cfg.nodata_value  = nodata_val_r;
  assign cfg.include_oor   = include_oor_r;

  phb_front #(
    .MAX_BINS    (MAX_BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .hold          (status.init_busy),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_sample     (in_sample),
    .in_bin_select (in_bin_select),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  phb_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (phb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  phb_back #(
    .MAX_BINS (MAX_BINS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .pop               (pop),
    .status            (status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bin_number    (out_bin_number),
    .out_bin_total     (out_bin_total),
    .out_nonnull_total (out_nonnull_total)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for pixel_histogram_binner_top: a shadow histogram predicts every bin
// read, while samples, reads and clears flow over valid/stall and setups go over APB.
// Depends on phb_pkg and the RTL in src.
module tb_top;

  localparam int HIST_BINS = phb_pkg::MAX_BINS_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 130;
  localparam int RANDOM_PHASES = 10;
  localparam int QUIET_LIMIT = 6000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [phb_pkg::ADDR_W-1:0] paddr = '0;
  logic [phb_pkg::DATA_W-1:0] pwdata = '0;
  logic [phb_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = phb_pkg::ACT_ACCUM;
  logic [phb_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic [phb_pkg::SEL_W-1:0] in_bin_select = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [phb_pkg::SEL_W-1:0] out_bin_number;
  logic [phb_pkg::COUNT_W-1:0] out_bin_total;
  logic [phb_pkg::COUNT_W-1:0] out_nonnull_total;

  pixel_histogram_binner_top u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct {
    logic [1:0]                   act;
    logic [phb_pkg::SAMPLE_W-1:0] sample;
    logic [phb_pkg::SEL_W-1:0]    sel;
    int                           gap;
  } pixel_op_t;

  typedef struct {
    logic [phb_pkg::SEL_W-1:0]   bin;
    logic [phb_pkg::COUNT_W-1:0] count;
    logic [phb_pkg::COUNT_W-1:0] total;
  } bin_report_t;

  pixel_op_t pending_ops[$];
  bin_report_t awaited_reports[$];
  logic [phb_pkg::COUNT_W-1:0] shadow_bins [HIST_BINS];
  logic [phb_pkg::COUNT_W-1:0] shadow_total;
  phb_pkg::cfg_t shadow_cfg;

  pixel_op_t staged;
  bit have_staged = 1'b0;
  int idle_left = 0;
  int report_hold = 0;
  int quiet_cycles = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int fail_count = 0;
  int ops_sent = 0;
  int reads_checked = 0;
  int clears_sent = 0;
  int setups_done = 0;

  function automatic logic [phb_pkg::COUNT_W-1:0] bump(logic [phb_pkg::COUNT_W-1:0] c);
    return (&c) ? c : c + 32'd1;
  endfunction

  function automatic int bins_in_use();
    int n;
    n = int'(shadow_cfg.bin_count);
    if (n == 0) n = 1;
    if (n > HIST_BINS) n = HIST_BINS;
    return n;
  endfunction

  // Bin index is the floor of (sample - low) * scale / 2^16, kept exact in 64 bits.
  task automatic tally_sample(logic [phb_pkg::SAMPLE_W-1:0] raw);
    longint s;
    longint diff;
    longint unsigned d;
    longint unsigned pos;
    int n;
    bit below;
    bit above;
    s = longint'($signed(raw));
    n = bins_in_use();
    below = 1'b0;
    above = 1'b0;
    pos = 0;
    if (shadow_cfg.nodata_enable && s == longint'($signed(shadow_cfg.nodata_value))) return;
    diff = s - longint'($signed(shadow_cfg.range_low));
    if (shadow_cfg.bin_scale == 32'd0) begin
      pos = 0;
    end else if (diff < 0) begin
      below = 1'b1;
    end else begin
      d = diff;
      pos = d * shadow_cfg.bin_scale[31:16] + ((d * shadow_cfg.bin_scale[15:0]) >> 16);
      above = (pos > n - 1);
    end
    if ((below || above) && !shadow_cfg.include_oor) return;
    if (above) pos = n - 1;
    shadow_bins[pos] = bump(shadow_bins[pos]);
    shadow_total = bump(shadow_total);
  endtask

  function automatic int draw_wait(bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 3))
      0: return 0;
      1, 2: return $urandom_range(0, 3);
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  task automatic queue_op(logic [1:0] act, logic [phb_pkg::SAMPLE_W-1:0] sample,
                          logic [phb_pkg::SEL_W-1:0] sel);
    pixel_op_t op;
    op.act = act;
    op.sample = sample;
    op.sel = sel;
    op.gap = draw_wait(in_calm);
    pending_ops.push_back(op);
  endtask

  // Mostly samples spread over the configured range with a margin on both sides.
  function automatic logic [phb_pkg::SAMPLE_W-1:0] pick_sample();
    longint span;
    longint v;
    longint unsigned r;
    longint unsigned m;
    if (shadow_cfg.bin_scale == 32'd0) span = 4000;
    else span = (longint'(bins_in_use()) * 65536) / longint'(shadow_cfg.bin_scale) + 2;
    case ($urandom_range(0, 9))
      0: return shadow_cfg.nodata_value;
      1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        r = {$urandom(), $urandom()};
        m = span + span / 8 + 1;
        v = longint'($signed(shadow_cfg.range_low)) - span / 16 + longint'(r % m);
      end
    endcase
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic write_reg(phb_pkg::reg_idx_t idx, logic [phb_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      phb_pkg::REG_BIN_COUNT:   shadow_cfg.bin_count = value[phb_pkg::BCNT_W-1:0];
      phb_pkg::REG_RANGE_LOW:   shadow_cfg.range_low = value;
      phb_pkg::REG_BIN_SCALE:   shadow_cfg.bin_scale = value;
      phb_pkg::REG_NODATA_EN:   shadow_cfg.nodata_enable = value[0];
      phb_pkg::REG_NODATA_VAL:  shadow_cfg.nodata_value = value;
      phb_pkg::REG_INCLUDE_OOR: shadow_cfg.include_oor = value[0];
      default: ;
    endcase
  endtask

  task automatic random_setup();
    logic [phb_pkg::DATA_W-1:0] count_w;
    logic [phb_pkg::DATA_W-1:0] low_w;
    logic [phb_pkg::DATA_W-1:0] scale_w;
    logic [phb_pkg::DATA_W-1:0] nd_w;
    case ($urandom_range(0, 7))
      0: count_w = 0;
      1: count_w = 1;
      2: count_w = HIST_BINS;
      3: count_w = 2047;
      4: count_w = $urandom_range(1, 16);
      5: count_w = $urandom_range(HIST_BINS + 1, 2047);
      default: count_w = $urandom_range(1, HIST_BINS);
    endcase
    case ($urandom_range(0, 7))
      0: low_w = 0;
      1: low_w = 32'h8000_0000;
      2: low_w = 32'h7FFF_FFFF;
      3: low_w = $urandom();
      default: low_w = $urandom_range(0, 2000) - 1000;
    endcase
    case ($urandom_range(0, 8))
      0: scale_w = 0;
      1: scale_w = 32'hFFFF_FFFF;
      2: scale_w = 32'h0001_0000;
      3: scale_w = 6554;  // bin width of ten, i.e. a reciprocal of 0.1
      4: scale_w = 65;    // bin width of about a thousand
      5: scale_w = 65536 / $urandom_range(1, 1000);
      6: scale_w = $urandom_range(1, 65535);
      7: scale_w = $urandom();
      default: scale_w = 65536 * $urandom_range(1, 4);
    endcase
    nd_w = $urandom_range(0, 1) ? low_w + $urandom_range(0, 40) : $urandom();
    write_reg(phb_pkg::REG_BIN_COUNT, count_w);
    write_reg(phb_pkg::REG_RANGE_LOW, low_w);
    write_reg(phb_pkg::REG_BIN_SCALE, scale_w);
    write_reg(phb_pkg::REG_NODATA_EN, $urandom_range(0, 1));
    write_reg(phb_pkg::REG_NODATA_VAL, nd_w);
    write_reg(phb_pkg::REG_INCLUDE_OOR, $urandom_range(0, 1));
    setups_done++;
  endtask

  // Repeated samples back to back exercise the forwarding path for the same bin.
  task automatic fill_random_phase();
    int made;
    int r;
    logic [phb_pkg::SAMPLE_W-1:0] last_sample;
    made = 0;
    last_sample = pick_sample();
    in_calm = ($urandom_range(0, 3) == 0);
    while (made < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 4) != 0) last_sample = pick_sample();
        queue_op(phb_pkg::ACT_ACCUM, last_sample, phb_pkg::SEL_W'($urandom()));
        made++;
      end else if (r < 94) begin
        queue_op(phb_pkg::ACT_READ, $urandom(), ($urandom_range(0, 3) == 0) ?
                 phb_pkg::SEL_W'($urandom_range(0, HIST_BINS - 1)) :
                 phb_pkg::SEL_W'($urandom_range(0, bins_in_use() - 1)));
        made++;
      end else if (r < 96) begin
        queue_op(phb_pkg::ACT_CLEAR, $urandom(), phb_pkg::SEL_W'($urandom()));
        made++;
      end else begin
        queue_op(ACT_UNUSED, $urandom(), phb_pkg::SEL_W'($urandom()));
      end
    end
    queue_op(phb_pkg::ACT_READ, $urandom(),
             phb_pkg::SEL_W'($urandom_range(0, bins_in_use() - 1)));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() != 0 || have_staged || in_valid ||
           awaited_reports.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Driver: each transfer updates the shadow histogram as it is taken.
  always @(posedge clk) begin : drive_ops
    bin_report_t rep;
    if (!rst_n) begin
      in_valid <= 1'b0;
      have_staged = 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        ops_sent++;
        case (in_action)
          phb_pkg::ACT_ACCUM: tally_sample(in_sample);
          phb_pkg::ACT_READ: begin
            rep.bin = in_bin_select;
            rep.count = shadow_bins[in_bin_select];
            rep.total = shadow_total;
            awaited_reports.push_back(rep);
          end
          phb_pkg::ACT_CLEAR: begin
            foreach (shadow_bins[i]) shadow_bins[i] = '0;
            shadow_total = '0;
            clears_sent++;
          end
          default: ;
        endcase
      end
      if (!(in_valid && in_stall)) begin
        if (!have_staged && pending_ops.size() != 0) begin
          staged = pending_ops.pop_front();
          have_staged = 1'b1;
          idle_left = staged.gap;
        end
        if (have_staged && idle_left == 0) begin
          in_valid <= 1'b1;
          in_action <= staged.act;
          in_sample <= staged.sample;
          in_bin_select <= staged.sel;
          have_staged = 1'b0;
        end else begin
          in_valid <= 1'b0;
          if (have_staged) idle_left--;
        end
      end
    end
  end

  always @(posedge clk) begin : check_reports
    bin_report_t want;
    if (out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected result for bin %0d", out_bin_number);
        fail_count++;
      end else begin
        want = awaited_reports.pop_front();
        reads_checked++;
        if (out_bin_number !== want.bin) begin
          $error("bin_number: expected %0d, got %0d", want.bin, out_bin_number);
          fail_count++;
        end
        if (out_bin_total !== want.count) begin
          $error("bin_total: expected %0d, got %0d", want.count, out_bin_total);
          fail_count++;
        end
        if (out_nonnull_total !== want.total) begin
          $error("nonnull_total: expected %0d, got %0d", want.total, out_nonnull_total);
          fail_count++;
        end
      end
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      report_hold = draw_wait(out_calm);
    end
    if (report_hold > 0) begin
      out_stall <= 1'b1;
      report_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    foreach (shadow_bins[i]) shadow_bins[i] = '0;
    shadow_total = '0;
    shadow_cfg.bin_count = 11'd256;
    shadow_cfg.range_low = '0;
    shadow_cfg.bin_scale = 32'h0001_0000;
    shadow_cfg.nodata_enable = 1'b0;
    shadow_cfg.nodata_value = '0;
    shadow_cfg.include_oor = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setup: edges of the range, dropped samples and an ignored action code.
    queue_op(phb_pkg::ACT_ACCUM, 32'd0, '0);
    queue_op(phb_pkg::ACT_ACCUM, 32'd0, '0);
    queue_op(phb_pkg::ACT_ACCUM, 32'd255, '0);
    queue_op(phb_pkg::ACT_ACCUM, 32'd256, '0);
    queue_op(phb_pkg::ACT_ACCUM, 32'hFFFF_FFFF, '0);
    queue_op(phb_pkg::ACT_ACCUM, 32'h7FFF_FFFF, '0);
    queue_op(phb_pkg::ACT_ACCUM, 32'h8000_0000, '0);
    queue_op(ACT_UNUSED, 32'd3, 10'd0);
    queue_op(phb_pkg::ACT_READ, '0, 10'd0);
    queue_op(phb_pkg::ACT_READ, '0, 10'd255);
    queue_op(phb_pkg::ACT_READ, '0, 10'h3FF);
    wait_drained();

    // Zero bin count and zero scale: every non-null sample lands in bin 0, even below low.
    write_reg(phb_pkg::REG_BIN_COUNT, 32'd0);
    write_reg(phb_pkg::REG_RANGE_LOW, 32'h7FFF_FFFF);
    write_reg(phb_pkg::REG_BIN_SCALE, 32'd0);
    write_reg(phb_pkg::REG_NODATA_EN, 32'd1);
    write_reg(phb_pkg::REG_NODATA_VAL, 32'hFFFF_FFF9);
    write_reg(phb_pkg::REG_INCLUDE_OOR, 32'd1);
    setups_done++;
    @(negedge clk);
    queue_op(phb_pkg::ACT_ACCUM, 32'hFFFF_FFF9, '0);
    queue_op(phb_pkg::ACT_ACCUM, 32'h8000_0000, '0);
    queue_op(phb_pkg::ACT_ACCUM, 32'd12345, '0);
    queue_op(phb_pkg::ACT_READ, '0, 10'd0);
    queue_op(phb_pkg::ACT_CLEAR, '0, '0);
    queue_op(phb_pkg::ACT_READ, '0, 10'd0);
    wait_drained();

    // Oversize bin count and full-scale reciprocal: large bins clamp into the last one.
    write_reg(phb_pkg::REG_BIN_COUNT, 32'd2047);
    write_reg(phb_pkg::REG_RANGE_LOW, 32'h8000_0000);
    write_reg(phb_pkg::REG_BIN_SCALE, 32'hFFFF_FFFF);
    write_reg(phb_pkg::REG_NODATA_EN, 32'd0);
    setups_done++;
    @(negedge clk);
    queue_op(phb_pkg::ACT_ACCUM, 32'h7FFF_FFFF, '0);
    queue_op(phb_pkg::ACT_ACCUM, 32'h8000_0000, '0);
    queue_op(phb_pkg::ACT_ACCUM, 32'h8000_0001, '0);
    queue_op(phb_pkg::ACT_READ, '0, 10'h3FF);
    queue_op(phb_pkg::ACT_READ, '0, 10'd0);
    queue_op(phb_pkg::ACT_READ, '0, 10'd300);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_setup();
      @(negedge clk);
      fill_random_phase();
      wait_drained();
    end

    $display("tb_top: %0d transfers driven, %0d bin reads compared, %0d clears",
             ops_sent, reads_checked, clears_sent);
    $display("tb_top: %0d register setups, zero and oversize bin counts and scales among them",
             setups_done);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== pixel_histogram_binner_top.f =====
src/phb_pkg.sv
src/phb_front.sv
src/phb_queue.sv
src/phb_back.sv
src/pixel_histogram_binner_top.sv
bench/tb_top.sv
